/* src/byc_pkg.sv */
// Shared widths, constants and index tables for the curvature pipeline.
`timescale 1ns / 1ps
`default_nettype none
package byc_pkg;

  // Unit normal and product rescaling use 28 fraction bits.
  localparam int NB       = 28;
  localparam int WORD_W   = 32;
  localparam int D_W      = 33;
  localparam int ROOT_W   = 32;
  localparam int R_W      = 34;
  localparam int IN_W     = 384;
  localparam int PS_W     = 192;
  localparam int OUT_W    = 192;

  // Normal division: 30 quotient bits, clipped at 1.0.
  localparam int N_QW     = 30;
  localparam int N_LIMB   = 28;
  localparam int N_W      = N_LIMB + 2;
  localparam int N_LAT    = N_QW + 2;

  // Term divisions: 47 quotient bits, clipped at 2^46.
  localparam int Q_QW     = 47;
  localparam int Q_LIMB   = 46;
  localparam int Q_W      = Q_LIMB + 2;
  localparam int Q_LAT    = Q_QW + 2;

  localparam int TERM_W   = 40;
  localparam int SUM_W    = Q_W + 1;

  localparam logic signed [SUM_W-1:0] TOT_MAX = 49'sd2147483647;
  localparam logic signed [SUM_W-1:0] TOT_MIN = -49'sd2147483648;

  // Row and column of each stored component: xx, xy, xz, yy, yz, zz.
  localparam int CA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int CB [6] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [N_W-1:0]    norm_t;
  typedef logic signed [Q_W-1:0]    qval_t;

endpackage
`default_nettype wire

/* src/byc_qdiv.sv */
// Pipelined signed divider: sign(x) * min(floor(|x| * 2^SH / d), 2^LIMB).
`timescale 1ns / 1ps
`default_nettype none
module byc_qdiv #(
  parameter int XW   = 48,
  parameter int DW   = 34,
  parameter int SH   = 16,
  parameter int QW   = 47,
  parameter int LIMB = 46
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [XW-1:0]  x,
  input  wire logic [DW-1:0]         d,
  output logic signed [LIMB+1:0]     y,
  output logic [DW-1:0]              d_out
);

  localparam int NW = XW + SH;
  localparam int CW = ((XW > DW + QW - SH) ? XW : DW + QW - SH) + 1;

  logic [XW-1:0]          ux;
  logic [NW-1:0]          num;
  logic                   ovf;
  logic [DW-1:0]          rem_r [0:QW];
  logic [QW-1:0]          lo_r  [0:QW];
  logic [DW-1:0]          d_r   [0:QW];
  logic                   neg_r [0:QW];
  logic                   ovf_r [0:QW];
  logic [QW-1:0]          lim;
  logic [QW-1:0]          quo;
  logic [LIMB:0]          mag;
  logic signed [LIMB+1:0] y_r;
  logic [DW-1:0]          d_out_r;

  assign ux  = x[XW-1] ? unsigned'(-x) : unsigned'(x);
  assign num = NW'(ux) << SH;
  // Quotient would not fit in QW bits: clip without dividing.
  assign ovf = CW'(ux) >= (CW'(d) << (QW - SH));

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num >> QW);
      lo_r[0]  <= num[QW-1:0];
      d_r[0]   <= d;
      neg_r[0] <= x[XW-1];
      ovf_r[0] <= ovf;
    end
  end

  // One quotient bit per stage; the low numerator bits shift out as quotient bits shift in.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] remx;
    logic        ge;
    assign remx = {rem_r[k], lo_r[k][QW-1]};
    assign ge   = remx >= {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? DW'(remx - {1'b0, d_r[k]}) : DW'(remx);
        lo_r[k+1]  <= {lo_r[k][QW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign lim = QW'(1) << LIMB;
  assign quo = lo_r[QW];
  assign mag = (ovf_r[QW] || quo > lim) ? (LIMB+1)'(lim) : (LIMB+1)'(quo);

  always_ff @(posedge clk) begin
    if (en) begin
      y_r     <= neg_r[QW] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      d_out_r <= d_r[QW];
    end
  end

  assign y     = y_r;
  assign d_out = d_out_r;

endmodule
`default_nettype wire

/* src/bowen_york_curvature_point_top.sv */
// Throughput: one transaction per cycle unless the output buffer is full and
//   out_tready is low; depth is set by the 32-stage square root, the 32-stage
//   normal divider and three chained 49-stage term dividers.
// A two-entry output buffer keeps in_tready high while one result waits.
// Reset (rst_n low, synchronous) clears all valid bits and empties the output buffer;
//   transactions in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none
module bowen_york_curvature_point_top
  import byc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // point_x, point_y, point_z, hole_x, hole_y, hole_z,
  // mom_x, mom_y, mom_z, spin_x, spin_y, spin_z (32 bits each)
  input  wire logic [IN_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // curv_xx, curv_xy, curv_xz, curv_yy, curv_yz, curv_zz (32 bits each)
  output logic [OUT_W-1:0]       out_tdata,
  // saturated
  output logic [0:0]             out_tuser
);

  localparam int S_R     = 4 + ROOT_W + 1;
  localparam int PS_LAST = S_R + N_LAT;
  localparam int LAT     = PS_LAST + 5 + 3 * Q_LAT;

  logic                    adv;
  logic [LAT-1:0]          vld_r;

  logic signed [D_W-1:0]   dd_r  [1:S_R][3];
  logic [PS_W-1:0]         psd_r [1:PS_LAST];
  logic                    sh_r  [2:S_R-1];
  logic [D_W-1:0]          mag_w [3];
  logic                    sh_w;
  logic [30:0]             t_r   [3];
  logic [61:0]             sq_r  [3];
  logic [63:0]             q_r;
  logic [34:0]             sq_rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0]       sq_root_r [0:ROOT_W-1];
  logic [63:0]             sq_qs_r   [0:ROOT_W-1];
  logic [ROOT_W-1:0]       root_w;
  logic [R_W-1:0]          r_r;

  norm_t                   n_w [3];
  logic [R_W-1:0]          rn_w;
  word_t                   p_w [3];
  word_t                   s_w [3];

  logic signed [61:0]      pnp_r [3][3];
  logic signed [61:0]      snp_r [3][2];
  logic signed [59:0]      nnp_r [6];
  norm_t                   na_r  [3];
  logic [R_W-1:0]          ra_r;

  logic signed [35:0]      pn_r;
  logic signed [34:0]      c_r   [3];
  logic signed [N_W-1:0]   nn_r  [6];
  logic signed [33:0]      pq_r  [3][3];
  norm_t                   nb_r  [3];
  logic [R_W-1:0]          rb_r;

  logic signed [65:0]      pnn_r [6];
  logic signed [64:0]      cn_r  [6][2];
  logic signed [33:0]      pqc_r [3][3];
  logic signed [35:0]      pnc_r;
  logic [R_W-1:0]          rc_r;

  logic signed [TERM_W-1:0] mterm_r [6];
  logic signed [TERM_W-1:0] sterm_r [6];
  logic [R_W-1:0]           rd_r;

  qval_t                   xm_r [6];
  qval_t                   xs_r [6];
  logic [R_W-1:0]          re_r;

  qval_t                   mdl_r [1:Q_LAT][6];
  qval_t                   mom_w [6];
  qval_t                   spn_w [6];
  logic [OUT_W-1:0]        res_data_w;
  logic                    res_sat_w;

  logic [1:0]              cnt_r;
  logic [OUT_W:0]          buf0_r;
  logic [OUT_W:0]          buf1_r;
  logic                    push;
  logic                    pop;
  logic [1:0]              slot;

  // Output buffer and global advance.
  assign pop       = (cnt_r != 2'd0) & out_tready;
  assign adv       = (cnt_r != 2'd2) | out_tready;
  assign push      = adv & vld_r[LAT-1];
  assign slot      = cnt_r - {1'b0, pop};
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= 2'd0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[LAT-2:0], in_tvalid};
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0_r <= buf1_r;
    end
    if (push) begin
      if (slot == 2'd0) begin
        buf0_r <= {res_sat_w, res_data_w};
      end else begin
        buf1_r <= {res_sat_w, res_data_w};
      end
    end
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = buf0_r[OUT_W-1:0];
  assign out_tuser  = buf0_r[OUT_W];

  // Separation vector and the momentum/spin payload line.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[1][i] <= D_W'(signed'(in_tdata[WORD_W*i +: WORD_W]))
                    - D_W'(signed'(in_tdata[WORD_W*(i+3) +: WORD_W]));
      end
      psd_r[1] <= in_tdata[IN_W-1:PS_W];
      for (int k = 2; k <= S_R; k++) begin
        dd_r[k] <= dd_r[k-1];
      end
      for (int k = 2; k <= PS_LAST; k++) begin
        psd_r[k] <= psd_r[k-1];
      end
      for (int k = 3; k < S_R; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  // Halve all magnitudes when any of them reaches 2^31 so the squares fit.
  always_comb begin
    sh_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = dd_r[1][i][D_W-1] ? unsigned'(-dd_r[1][i]) : unsigned'(dd_r[1][i]);
      sh_w     = sh_w | mag_w[i][D_W-1] | mag_w[i][D_W-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[2] <= sh_w;
      for (int i = 0; i < 3; i++) begin
        t_r[i]  <= sh_w ? mag_w[i][31:1] : mag_w[i][30:0];
        sq_r[i] <= 62'(t_r[i]) * 62'(t_r[i]);
      end
      q_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [63:0]       qs_in;
    logic [34:0]       rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [34:0]       remx;
    logic [34:0]       trial;
    logic              ge;
    if (k == 0) begin : g_first
      assign qs_in   = q_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign qs_in   = sq_qs_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
    end
    assign remx  = {rem_in[32:0], qs_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = remx >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k]  <= ge ? remx - trial : remx;
        sq_root_r[k] <= {root_in[ROOT_W-2:0], ge};
        sq_qs_r[k]   <= {qs_in[61:0], 2'b00};
      end
    end
  end

  assign root_w = sq_root_r[ROOT_W-1];

  // Undo the halving; a point on the hole gets the smallest distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (root_w == '0) begin
        r_r <= R_W'(1);
      end else if (sh_r[S_R-1]) begin
        r_r <= {1'b0, root_w, 1'b0};
      end else begin
        r_r <= {2'b00, root_w};
      end
    end
  end

  // Unit normal: n = d * 2^28 / r, clipped to 1.0.
  for (genvar i = 0; i < 3; i++) begin : g_norm
    if (i == 0) begin : g_lead
      byc_qdiv #(
        .XW(D_W), .DW(R_W), .SH(NB), .QW(N_QW), .LIMB(N_LIMB)
      ) u_ndiv (
        .clk(clk), .en(adv), .x(dd_r[S_R][i]), .d(r_r), .y(n_w[i]), .d_out(rn_w)
      );
    end else begin : g_rest
      byc_qdiv #(
        .XW(D_W), .DW(R_W), .SH(NB), .QW(N_QW), .LIMB(N_LIMB)
      ) u_ndiv (
        .clk(clk), .en(adv), .x(dd_r[S_R][i]), .d(r_r), .y(n_w[i]), .d_out()
      );
    end
    assign p_w[i] = signed'(psd_r[PS_LAST][WORD_W*i +: WORD_W]);
    assign s_w[i] = signed'(psd_r[PS_LAST][WORD_W*(i+3) +: WORD_W]);
  end

  // Products with the normal.
  for (genvar i = 0; i < 3; i++) begin : g_prod_a
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int j = 0; j < 3; j++) begin
          pnp_r[i][j] <= 62'(p_w[i]) * 62'(n_w[j]);
        end
        snp_r[i][0] <= 62'(s_w[I1]) * 62'(n_w[I2]);
        snp_r[i][1] <= 62'(s_w[I2]) * 62'(n_w[I1]);
        na_r[i]     <= n_w[i];
      end
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_nn
    always_ff @(posedge clk) begin
      if (adv) begin
        nnp_r[k] <= 60'(n_w[CA[k]]) * 60'(n_w[CB[k]]);
      end
    end
  end

  // Rescale to the working formats; floor on every shift.
  always_ff @(posedge clk) begin
    if (adv) begin
      ra_r <= rn_w;
      rb_r <= ra_r;
      rc_r <= rb_r;
      rd_r <= rc_r;
      re_r <= rd_r;
      pn_r <= 36'((64'(pnp_r[0][0]) + 64'(pnp_r[1][1]) + 64'(pnp_r[2][2])) >>> NB);
      pnc_r <= pn_r;
      for (int i = 0; i < 3; i++) begin
        c_r[i]  <= 35'((63'(snp_r[i][0]) - 63'(snp_r[i][1])) >>> NB);
        nb_r[i] <= na_r[i];
        for (int j = 0; j < 3; j++) begin
          pq_r[i][j]  <= 34'(pnp_r[i][j] >>> NB);
          pqc_r[i][j] <= pq_r[i][j];
        end
      end
      for (int k = 0; k < 6; k++) begin
        nn_r[k] <= N_W'(nnp_r[k] >>> NB);
      end
    end
  end

  // Momentum and spin terms per component.
  for (genvar k = 0; k < 6; k++) begin : g_term
    localparam int A = CA[k];
    localparam int B = CB[k];
    logic signed [TERM_W-1:0] diag;
    assign diag = (A == B) ? TERM_W'(pnc_r) : '0;
    always_ff @(posedge clk) begin
      if (adv) begin
        pnn_r[k]    <= 66'(pn_r) * 66'(nn_r[k]);
        cn_r[k][0]  <= 65'(c_r[A]) * 65'(nb_r[B]);
        cn_r[k][1]  <= 65'(c_r[B]) * 65'(nb_r[A]);
        mterm_r[k]  <= TERM_W'(pqc_r[A][B]) + TERM_W'(pqc_r[B][A])
                     + TERM_W'(pnn_r[k] >>> NB) - diag;
        sterm_r[k]  <= TERM_W'(cn_r[k][0] >>> NB) + TERM_W'(cn_r[k][1] >>> NB);
        xm_r[k]     <= Q_W'(mterm_r[k]) + (Q_W'(mterm_r[k]) <<< 1);
        xs_r[k]     <= Q_W'(sterm_r[k]) + (Q_W'(sterm_r[k]) <<< 1);
      end
    end

    // Momentum: (3M / r) / (2r), then held to line up with the spin chain.
    qval_t          m1_y;
    logic [R_W-1:0] m1_d;
    byc_qdiv #(
      .XW(Q_W), .DW(R_W), .SH(FRAC_BITS), .QW(Q_QW), .LIMB(Q_LIMB)
    ) u_mdiv1 (
      .clk(clk), .en(adv), .x(xm_r[k]), .d(re_r), .y(m1_y), .d_out(m1_d)
    );
    qval_t m2_y;
    byc_qdiv #(
      .XW(Q_W), .DW(R_W), .SH(FRAC_BITS), .QW(Q_QW), .LIMB(Q_LIMB)
    ) u_mdiv2 (
      .clk(clk), .en(adv), .x(m1_y), .d({m1_d[R_W-2:0], 1'b0}), .y(m2_y), .d_out()
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        mdl_r[1][k] <= m2_y;
        for (int t = 2; t <= Q_LAT; t++) begin
          mdl_r[t][k] <= mdl_r[t-1][k];
        end
      end
    end
    assign mom_w[k] = mdl_r[Q_LAT][k];

    // Spin: ((3T / r) / r) / r.
    qval_t          s1_y;
    qval_t          s2_y;
    logic [R_W-1:0] s1_d;
    logic [R_W-1:0] s2_d;
    byc_qdiv #(
      .XW(Q_W), .DW(R_W), .SH(FRAC_BITS), .QW(Q_QW), .LIMB(Q_LIMB)
    ) u_sdiv1 (
      .clk(clk), .en(adv), .x(xs_r[k]), .d(re_r), .y(s1_y), .d_out(s1_d)
    );
    byc_qdiv #(
      .XW(Q_W), .DW(R_W), .SH(FRAC_BITS), .QW(Q_QW), .LIMB(Q_LIMB)
    ) u_sdiv2 (
      .clk(clk), .en(adv), .x(s1_y), .d(s1_d), .y(s2_y), .d_out(s2_d)
    );
    byc_qdiv #(
      .XW(Q_W), .DW(R_W), .SH(FRAC_BITS), .QW(Q_QW), .LIMB(Q_LIMB)
    ) u_sdiv3 (
      .clk(clk), .en(adv), .x(s2_y), .d(s2_d), .y(spn_w[k]), .d_out()
    );
  end

  // Sum both terms and clip to 32 bits.
  always_comb begin
    logic signed [SUM_W-1:0] tot;
    res_sat_w  = 1'b0;
    res_data_w = '0;
    for (int k = 0; k < 6; k++) begin
      tot = SUM_W'(mom_w[k]) + SUM_W'(spn_w[k]);
      if (tot > TOT_MAX) begin
        res_data_w[WORD_W*k +: WORD_W] = TOT_MAX[WORD_W-1:0];
        res_sat_w = 1'b1;
      end else if (tot < TOT_MIN) begin
        res_data_w[WORD_W*k +: WORD_W] = TOT_MIN[WORD_W-1:0];
        res_sat_w = 1'b1;
      end else begin
        res_data_w[WORD_W*k +: WORD_W] = tot[WORD_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* src/byc_checker.sv */
// Port-level checks for the curvature pipeline, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module byc_checker
  import byc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [IN_W-1:0]   in_tdata,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_W-1:0]  out_tdata,
  input wire logic [0:0]        out_tuser
);

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Input backpressure only comes from a stalled, full output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // A refused result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output transaction withdrawn");

  // A refused result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("output payload changed while stalled");

endmodule

bind bowen_york_curvature_point_top byc_checker u_byc_checker (.*);
`default_nettype wire
